/* sv/infix_to_postfix_converter_core_macros.svh */
// assertion macros for the infix-to-postfix converter
// expects clk and rst_n in the scope where a macro is used
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/itp_pkg.sv */
// itp_pkg: operator codes, token classes and precedence helpers
// for the infix-to-postfix converter; no dependencies
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int CODE_W          = 3;

    typedef logic [CODE_W-1:0] op_code_t;

    localparam op_code_t OP_LPAR = 3'd0;
    localparam op_code_t OP_ADD  = 3'd1;
    localparam op_code_t OP_SUB  = 3'd2;
    localparam op_code_t OP_MUL  = 3'd3;
    localparam op_code_t OP_DIV  = 3'd4;
    localparam op_code_t OP_POW  = 3'd5;

    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_POW  = 8'h5E;
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef enum logic [2:0] {
        K_IGNORE,
        K_ECHO,
        K_LPAR,
        K_RPAR,
        K_OP
    } tok_kind_t;

    function automatic tok_kind_t tok_kind(logic [7:0] t);
        tok_kind_t k;
        case (t) inside
            [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: k = K_ECHO;
            CH_LPAR:                                     k = K_LPAR;
            CH_RPAR:                                     k = K_RPAR;
            CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW:      k = K_OP;
            default:                                     k = K_IGNORE;
        endcase
        return k;
    endfunction

    function automatic op_code_t op_of(logic [7:0] t);
        op_code_t c;
        case (t)
            CH_ADD:  c = OP_ADD;
            CH_SUB:  c = OP_SUB;
            CH_MUL:  c = OP_MUL;
            CH_DIV:  c = OP_DIV;
            CH_POW:  c = OP_POW;
            default: c = OP_LPAR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] code_char(op_code_t c);
        logic [7:0] ch;
        case (c)
            OP_LPAR: ch = CH_LPAR;
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            OP_MUL:  ch = CH_MUL;
            OP_DIV:  ch = CH_DIV;
            OP_POW:  ch = CH_POW;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] code_prec(op_code_t c);
        logic [1:0] p;
        case (c)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            OP_POW:         p = 2'd3;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

    // '^' is right-associative, everything else left
    function automatic logic should_pop(op_code_t incoming, op_code_t top);
        logic r;
        if (incoming == OP_POW) begin
            r = code_prec(incoming) < code_prec(top);
        end else begin
            r = code_prec(incoming) <= code_prec(top);
        end
        return r;
    endfunction

endpackage

/* sv/infix_to_postfix_converter_core.sv */
// infix_to_postfix_converter_core: shunting-yard converter, one byte per transaction
// depends on itp_pkg and infix_to_postfix_converter_core_macros.svh
//
//  channel | signals                                   | dir | contents
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, token, end_of_expr    | in  | one infix byte
//  out     | out_valid, out_ready, out_char,           | out | one postfix char or
//          | is_terminator, overflow, run_last         |     | the terminator
//
// an ignored byte, a letter/digit or '(' passes through S_IDLE, S_START and S_FIN; ')' and
// operators add an S_READ, an S_READ and S_EVAL pair per popped entry, and one more S_EVAL
// when the scan stops on a nonempty stack; end_of_expr adds an S_FREAD and S_FPOP pair per
// flushed entry, a last S_FREAD and S_TERM; each pop reads, then evaluates, the stack ram.
// reset clears count, overflow flag and handshake state; the stack ram is not cleared.
// a stalled out channel holds the sequencer once the one-deep holding slot is full.
`include "infix_to_postfix_converter_core_macros.svh"

module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] token,
    input  logic       end_of_expr,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       is_terminator,
    output logic       overflow,
    output logic       run_last
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_EVAL  = 8'b0000_1000,
        S_FREAD = 8'b0001_0000,
        S_FPOP  = 8'b0010_0000,
        S_TERM  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_seen_reg, ovf_seen_next;
    logic [7:0]     tok_reg;
    logic           eoe_reg;

    op_code_t       stack_mem [STACK_DEPTH];
    op_code_t       rd_data_reg;
    logic           rd_en, wr_en;
    logic [AW-1:0]  rd_addr, wr_addr;
    op_code_t       wr_data;

    // one-deep holding slot: a result leaves only once we know if another follows
    logic           pend_valid_reg;
    logic [7:0]     pend_char_reg;
    logic           pend_term_reg, pend_ovf_reg;

    logic           out_valid_reg, out_term_reg, out_ovf_reg, run_last_reg;
    logic [7:0]     out_char_reg;

    logic           emit_req, fin_req, can_emit, out_free, move;
    logic [7:0]     emit_char;
    logic           emit_term, emit_ovf;
    tok_kind_t      kind;
    op_code_t       tok_op;
    logic           full, empty, pop_it;
    state_t         after_tok;

    assign kind      = tok_kind(tok_reg);
    assign tok_op    = op_of(tok_reg);
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign after_tok = eoe_reg ? S_FREAD : S_FIN;
    assign out_free  = !out_valid_reg || out_ready;
    assign can_emit  = !pend_valid_reg || out_free;
    assign move      = pend_valid_reg && out_free && (emit_req || fin_req);
    assign pop_it    = (rd_data_reg != OP_LPAR) &&
                       ((kind == K_RPAR) || should_pop(tok_op, rd_data_reg));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_seen_next = ovf_seen_reg;
        in_ready      = 1'b0;
        emit_req      = 1'b0;
        emit_char     = CH_NUL;
        emit_term     = 1'b0;
        emit_ovf      = 1'b0;
        fin_req       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = AW'(count_reg - 1'b1);
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = tok_op;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (kind)
                    K_ECHO:
                    begin
                        emit_req  = 1'b1;
                        emit_char = tok_reg;
                        if (can_emit) begin
                            state_next = after_tok;
                        end
                    end
                    K_LPAR:
                    begin
                        wr_data = OP_LPAR;
                        if (full) begin
                            ovf_seen_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = after_tok;
                    end
                    K_RPAR, K_OP:
                    begin
                        state_next = S_READ;
                    end
                    default:
                    begin
                        state_next = after_tok;
                    end
                endcase
            end
            S_READ:
            begin
                if (empty) begin
                    if (kind == K_OP) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = after_tok;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (pop_it) begin
                    emit_req  = 1'b1;
                    emit_char = code_char(rd_data_reg);
                    if (can_emit) begin
                        count_next = count_reg - 1'b1;
                        state_next = S_READ;
                    end
                end else if (kind == K_RPAR) begin
                    // matching '(' is dropped
                    count_next = count_reg - 1'b1;
                    state_next = after_tok;
                end else begin
                    if (full) begin
                        ovf_seen_next = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = after_tok;
                end
            end
            S_FREAD:
            begin
                if (empty) begin
                    state_next = S_TERM;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_FPOP;
                end
            end
            S_FPOP:
            begin
                emit_req  = 1'b1;
                emit_char = code_char(rd_data_reg);
                if (can_emit) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FREAD;
                end
            end
            S_TERM:
            begin
                emit_req  = 1'b1;
                emit_term = 1'b1;
                emit_ovf  = ovf_seen_reg;
                if (can_emit) begin
                    ovf_seen_next = 1'b0;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                fin_req = 1'b1;
                if (can_emit) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // stack ram; writes and reads never target the same cycle, so no bypass
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_seen_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_seen_reg <= ovf_seen_next;
            if (emit_req && can_emit) begin
                pend_valid_reg <= 1'b1;
            end else if (move) begin
                pend_valid_reg <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            tok_reg <= token;
            eoe_reg <= end_of_expr;
        end
        if (emit_req && can_emit) begin
            pend_char_reg <= emit_char;
            pend_term_reg <= emit_term;
            pend_ovf_reg  <= emit_ovf;
        end
        if (move) begin
            out_char_reg <= pend_char_reg;
            out_term_reg <= pend_term_reg;
            out_ovf_reg  <= pend_ovf_reg;
            run_last_reg <= fin_req;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign is_terminator = out_term_reg;
    assign overflow      = out_ovf_reg;
    assign run_last      = run_last_reg;

    `ITP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(STACK_DEPTH), "stack count past depth")
    `ITP_ASSERT_NOW(a_idle_drained, in_ready, !pend_valid_reg, "new transaction with result held")
    `ITP_ASSERT_NOW(a_term_last, out_valid_reg && out_term_reg, run_last_reg, "terminator not last")
    `ITP_ASSERT_NEXT(a_term_clears, (state_reg == S_TERM) && can_emit,
        (count_reg == '0) && !ovf_seen_reg, "state not cleared after terminator")

endmodule

/* verif/postfix_checker.sv */
// postfix_checker: watches both channels of the infix-to-postfix converter,
// predicts the postfix stream from each accepted token and compares every result
// depends on itp_pkg for the character constants
module postfix_checker #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] token,
    input  logic       end_of_expr,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_char,
    input  logic       is_terminator,
    input  logic       overflow,
    input  logic       run_last,
    output int         failures,
    output int         pending
);
    import itp_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       term;
        logic       ovf;
        logic       last;
    } postfix_item_t;

    // operator stack kept as characters, top at held_depth-1
    logic [7:0]    held_ops [STACK_DEPTH];
    int            held_depth;
    logic          dropped_push;
    postfix_item_t expected_postfix [$];
    postfix_item_t want;
    int            mismatch_count = 0;

    function automatic int binding(logic [7:0] ch);
        int b;
        b = 0;
        if (ch == CH_POW) b = 3;
        else if (ch == CH_MUL || ch == CH_DIV) b = 2;
        else if (ch == CH_ADD || ch == CH_SUB) b = 1;
        return b;
    endfunction

    task automatic hold(input logic [7:0] ch);
        if (held_depth >= STACK_DEPTH) begin
            dropped_push = 1'b1;
        end else begin
            held_ops[held_depth] = ch;
            held_depth++;
        end
    endtask

    task automatic convert_token(input logic [7:0] t, input logic e);
        postfix_item_t run [$];
        postfix_item_t r;
        int            p;
        int            k;
        p = binding(t);
        if ((t >= "0" && t <= "9") || (t >= "A" && t <= "Z") || (t >= "a" && t <= "z")) begin
            run.push_back({t, 3'b000});
        end else if (t == CH_LPAR) begin
            hold(CH_LPAR);
        end else if (t == CH_RPAR) begin
            while (held_depth > 0 && held_ops[held_depth-1] != CH_LPAR) begin
                held_depth--;
                run.push_back({held_ops[held_depth], 3'b000});
            end
            if (held_depth > 0) held_depth--;
        end else if (p > 0) begin
            // '^' yields only to a tighter operator, the others to an equal one too
            while (held_depth > 0 && held_ops[held_depth-1] != CH_LPAR &&
                   (p < binding(held_ops[held_depth-1]) ||
                    (t != CH_POW && p == binding(held_ops[held_depth-1])))) begin
                held_depth--;
                run.push_back({held_ops[held_depth], 3'b000});
            end
            hold(t);
        end
        if (e) begin
            while (held_depth > 0) begin
                held_depth--;
                run.push_back({held_ops[held_depth], 3'b000});
            end
            run.push_back({CH_NUL, 1'b1, dropped_push, 1'b0});
            dropped_push = 1'b0;
        end
        if (run.size() > 0) begin
            r = run.pop_back();
            r.last = 1'b1;
            run.push_back(r);
        end
        for (k = 0; k < run.size(); k++) expected_postfix.push_back(run[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_depth = 0;
            dropped_push = 1'b0;
            expected_postfix.delete();
        end
        else
        begin
            // input first so a same-cycle result still finds its expectation
            if (in_valid && in_ready) convert_token(token, end_of_expr);
            if (out_valid && out_ready)
            begin
                if (expected_postfix.size() == 0)
                begin
                    $error("unexpected transaction: out_char %h is_terminator %b",
                           out_char, is_terminator);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_postfix.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $error("out_char: expected %h, got %h", want.ch, out_char);
                        mismatch_count++;
                    end
                    if (is_terminator !== want.term)
                    begin
                        $error("is_terminator: expected %b, got %b", want.term, is_terminator);
                        mismatch_count++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %b, got %b", want.ovf, overflow);
                        mismatch_count++;
                    end
                    if (run_last !== want.last)
                    begin
                        $error("run_last: expected %b, got %b", want.last, run_last);
                        mismatch_count++;
                    end
                end
            end
        end
        failures <= mismatch_count;
        pending  <= expected_postfix.size();
    end

endmodule

/* verif/testbench.sv */
// testbench: drives infix expressions into infix_to_postfix_converter_core and
// gives the verdict; depends on itp_pkg, the core and postfix_checker
module testbench;
    import itp_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int MAX_CYCLES  = 1_000_000;
    localparam int TAIL_CYCLES = 200;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] token;
    logic       end_of_expr;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_char;
    logic       is_terminator;
    logic       overflow;
    logic       run_last;
    int         failures;
    int         pending;
    int         cycle_count   = 0;
    int         live_items    = 0;
    int         send_idle_pct = 20;
    int         recv_idle_pct = 82;

    infix_to_postfix_converter_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .token(token), .end_of_expr(end_of_expr),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_char(out_char), .is_terminator(is_terminator),
        .overflow(overflow), .run_last(run_last)
    );

    postfix_checker #(.STACK_DEPTH(STACK_DEPTH)) chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .token(token), .end_of_expr(end_of_expr),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_char(out_char), .is_terminator(is_terminator),
        .overflow(overflow), .run_last(run_last),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] random_operand();
        logic [7:0] ch;
        case ($urandom_range(2))
            0:       ch = 8'("0" + $urandom_range(9));
            1:       ch = 8'("A" + $urandom_range(25));
            default: ch = 8'("a" + $urandom_range(25));
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] random_operator();
        logic [7:0] ch;
        case ($urandom_range(4))
            0:       ch = CH_ADD;
            1:       ch = CH_SUB;
            2:       ch = CH_MUL;
            3:       ch = CH_DIV;
            default: ch = CH_POW;
        endcase
        return ch;
    endfunction

    // one transaction; valid stays up between back-to-back items
    task automatic send_item(input logic [7:0] t, input logic e);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid    <= 1'b1;
        token       <= t;
        end_of_expr <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (e || t == CH_LPAR || t == CH_RPAR || t == CH_ADD || t == CH_SUB ||
            t == CH_MUL || t == CH_DIV || t == CH_POW ||
            (t >= "0" && t <= "9") || (t >= "A" && t <= "Z") || (t >= "a" && t <= "z"))
            live_items++;
    endtask

    // sends a line with stray whitespace mixed in, end marker on its last byte
    task automatic send_line(input logic [7:0] line [$]);
        int         k;
        int         w;
        logic [7:0] blank;
        for (k = 0; k < line.size(); k++)
        begin
            if ($urandom_range(5) == 0)
            begin
                w = $urandom_range(5);
                blank = (w == 5) ? 8'h20 : 8'(8'h09 + w);
                send_item(blank, 1'b0);
            end
            send_item(line[k], k == line.size() - 1);
        end
    endtask

    task automatic send_formula();
        logic [7:0] line [$];
        int         terms;
        int         nest;
        int         k;
        terms = $urandom_range(1, 8);
        nest = 0;
        for (k = 0; k < terms; k++)
        begin
            while (nest < 5 && $urandom_range(3) == 0)
            begin
                line.push_back(CH_LPAR);
                nest++;
            end
            line.push_back(random_operand());
            while (nest > 0 && $urandom_range(2) == 0)
            begin
                line.push_back(CH_RPAR);
                nest--;
            end
            if (k != terms - 1) line.push_back(random_operator());
        end
        while (nest > 0)
        begin
            line.push_back(CH_RPAR);
            nest--;
        end
        send_line(line);
    endtask

    // fills the stack to within six entries of its depth, or up to six past it
    task automatic send_deep();
        logic [7:0] line [$];
        int         n;
        int         k;
        n = $urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 6);
        if ($urandom_range(1))
        begin
            for (k = 0; k < n; k++) line.push_back(CH_LPAR);
            line.push_back(random_operand());
            k = $urandom_range(n);
            repeat (k) line.push_back(CH_RPAR);
        end
        else
        begin
            // a right-associative chain pops no '^', so each one is pushed while the stack has room
            for (k = 0; k < n; k++)
            begin
                line.push_back(random_operand());
                line.push_back(CH_POW);
            end
            line.push_back(random_operand());
        end
        send_line(line);
    endtask

    task automatic send_noise();
        int         n;
        int         k;
        logic [7:0] t;
        n = $urandom_range(2, 12);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(3))
                0:       t = 8'($urandom_range(255));
                1:       t = random_operator();
                2:       t = random_operand();
                default: t = $urandom_range(1) ? CH_LPAR : CH_RPAR;
            endcase
            send_item(t, k == n - 1 || $urandom_range(9) == 0);
        end
    endtask

    initial
    begin
        logic [7:0] directed [$];
        int         k;
        int         phase;
        int         pick;
        directed = '{8'h00, 8'hFF, 8'h20, 8'h09, 8'h0D, "A", CH_ADD, "z", CH_SUB, "0",
                     CH_MUL, "9", CH_DIV, "Z", CH_POW, "a", CH_POW, "1", CH_RPAR,
                     CH_LPAR, 8'h80, CH_RPAR};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        token       = 8'h00;
        end_of_expr = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the last two carry the end marker: a stray byte left on an unmatched '(', then a lone ')'
        for (k = 0; k < directed.size(); k++)
            send_item(directed[k], k >= directed.size() - 2);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct <= 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct <= 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            while (live_items < 65 * (phase + 1))
            begin
                pick = $urandom_range(99);
                if (pick < 70) send_formula();
                else if (pick < 82) send_deep();
                else send_noise();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/itp_pkg.sv
sv/infix_to_postfix_converter_core.sv
verif/postfix_checker.sv
verif/testbench.sv
